### sv/wav_riff_stream_parser_assert.svh
// Assertion macros for the RIFF/WAVE stream parser checker.
`ifndef WAV_RIFF_STREAM_PARSER_ASSERT_SVH
`define WAV_RIFF_STREAM_PARSER_ASSERT_SVH
// Implication checked every clock, disabled in reset.
`define WRP_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked every clock, disabled in reset.
`define WRP_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### sv/wrp_pkg.sv
// Shared types and constants of the RIFF/WAVE stream parser.
`timescale 1ns / 1ps
`default_nettype none
package wrp_pkg;
    localparam logic [31:0] TAG_RIFF = 32'h46464952;
    localparam logic [31:0] TAG_WAVE = 32'h45564157;
    localparam logic [31:0] TAG_FMT  = 32'h20746D66;
    localparam logic [31:0] TAG_DATA = 32'h61746164;
    localparam logic [31:0] TAG_SMPL = 32'h6C706D73;
    localparam logic [7:0]  SAMPLE_BIAS = 8'd128;
    localparam logic [31:0] FMT_BODY_SIZE = 32'd16;
    localparam logic [31:0] SMPL_MIN_BODY = 32'd60;

    localparam logic [4:0] ST_OK        = 5'd0;
    localparam logic [4:0] ST_SMALL     = 5'd1;
    localparam logic [4:0] ST_NO_RIFF   = 5'd2;
    localparam logic [4:0] ST_SIZE      = 5'd3;
    localparam logic [4:0] ST_NO_WAVE   = 5'd4;
    localparam logic [4:0] ST_FMT_SIZE  = 5'd5;
    localparam logic [4:0] ST_NOT_PCM   = 5'd6;
    localparam logic [4:0] ST_NOT_MONO  = 5'd7;
    localparam logic [4:0] ST_BYTE_RATE = 5'd8;
    localparam logic [4:0] ST_ALIGN     = 5'd9;
    localparam logic [4:0] ST_DATA_EARLY = 5'd10;
    localparam logic [4:0] ST_SMPL_EARLY = 5'd11;
    localparam logic [4:0] ST_LOOP_CNT  = 5'd12;
    localparam logic [4:0] ST_LOOP_TYPE = 5'd13;
    localparam logic [4:0] ST_PLAY_CNT  = 5'd14;
    localparam logic [4:0] ST_NO_DATA   = 5'd15;
    localparam logic [4:0] ST_DEPTH     = 5'd16;
    localparam logic [4:0] ST_TRUNC     = 5'd17;

    // One result item as handed from the parser core to the output stage.
    typedef struct packed {
        logic        kind;
        logic [7:0]  sample;
        logic [4:0]  status;
        logic [31:0] rate;
        logic [15:0] depth;
        logic [31:0] loop_start;
        logic [31:0] loop_length;
        logic [31:0] sample_count;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
endpackage
`default_nettype wire

### sv/wav_riff_stream_parser.sv
// Top level of the RIFF/WAVE PCM stream parser.
// Usage:
//  Slave channel s_axis_*: one file byte per item, tlast on the final byte.
//  Master channel m_axis_*: results. tuser=0 is a sample (tdata[7:0] signed),
//  tuser=1 is the final report with status, rate, depth, loop and count.
//  Each byte is parsed in the cycle it is accepted; its results are written
//  into a four-entry queue whose head drives the master side.
//  Throughput: one byte per cycle while the receiver keeps up; the final
//  byte can yield two results, which leave the queue one after the other, so a
//  report landing on a queue that already holds two results stalls the input.
//  s_axis_tready drops only when the queue cannot hold two more results.
//  Reset clears the parser to the start of a file and empties the queue.
//  After each report the parser returns to the start of a new file.
//  A stalled receiver holds the head result steady until taken.
`timescale 1ns / 1ps
`default_nettype none
module wav_riff_stream_parser
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire logic         s_axis_tlast,   // last_byte
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output      logic [159:0] m_axis_tdata,   // sample_value[7:0], status[12:8],
                                              // rate_out[44:13], depth_out[60:45],
                                              // loop_start_out[92:61],
                                              // loop_length_out[124:93],
                                              // sample_count_out[156:125], zero pad
    output      logic         m_axis_tuser    // result_kind
);
    logic             step, smp_valid, rep_valid, room;
    wrp_pkg::result_t smp_res, rep_res, head;

    assign s_axis_tready = room;
    assign step = s_axis_tvalid && room;

    wrp_core u_core
    (
        .clk(clk), .rst_n(rst_n), .step(step),
        .data_byte(s_axis_tdata), .last_byte(s_axis_tlast),
        .smp_valid(smp_valid), .smp_res(smp_res),
        .rep_valid(rep_valid), .rep_res(rep_res)
    );

    wrp_out_fifo u_fifo
    (
        .clk(clk), .rst_n(rst_n),
        .a_valid(step && smp_valid), .a_res(smp_res),
        .b_valid(step && rep_valid), .b_res(rep_res),
        .room(room), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_res(head)
    );

    assign m_axis_tuser = head.kind;
    assign m_axis_tdata = {3'd0, head.sample_count, head.loop_length, head.loop_start,
                           head.depth, head.rate, head.status, head.sample};
endmodule
`default_nettype wire

### sv/wrp_core.sv
// Parser state and per-byte update for the RIFF/WAVE stream parser.
`timescale 1ns / 1ps
`default_nettype none
module wrp_core
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,       // one byte item taken this cycle
    input  wire logic [7:0]           data_byte,
    input  wire logic                 last_byte,
    output      logic                 smp_valid,
    output      wrp_pkg::result_t     smp_res,
    output      logic                 rep_valid,
    output      wrp_pkg::result_t     rep_res
);
    typedef enum logic [1:0] {PH_RIFF, PH_CHDR, PH_BODY, PH_HALT} phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] riff_size_reg, riff_size_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] off_reg, off_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic        data_seen_reg, data_seen_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] depth_reg, depth_next;
    logic [31:0] brate_reg, brate_next;
    logic [31:0] dlen_reg, dlen_next;
    logic [31:0] lbeg_reg, lbeg_next;
    logic [31:0] lspan_reg, lspan_next;
    logic [31:0] lend_reg, lend_next;
    logic [31:0] lstart_reg, lstart_next;
    logic [4:0]  err_reg, err_next;
    // byte rate check: stored rate times the bits field at fmt offset 15, kept to 32 bits
    logic [31:0] prod;
    logic [31:0] lend_clamp;
    logic [4:0]  st;
    logic        fail;
    logic [4:0]  fail_code;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next = (pos_reg != 32'hFFFFFFFF) ? pos_reg + 32'd1 : pos_reg;
        riff_size_next = riff_size_reg;
        word_next = {data_byte, word_reg[31:8]};
        tag_next = tag_reg;
        left_next = left_reg;
        off_next = off_reg;
        fmt_seen_next = fmt_seen_reg;
        data_seen_next = data_seen_reg;
        rate_next = rate_reg;
        depth_next = depth_reg;
        brate_next = brate_reg;
        dlen_next = dlen_reg;
        lbeg_next = lbeg_reg;
        lspan_next = lspan_reg;
        lend_next = lend_reg;
        lstart_next = lstart_reg;
        fail = 1'b0;
        fail_code = wrp_pkg::ST_OK;
        smp_valid = 1'b0;
        smp_res = '0;
        prod = rate_reg * {16'd0, word_next[31:16]};
        lend_clamp = (lend_reg > dlen_reg) ? dlen_reg : lend_reg;

        case (phase_reg)
            PH_RIFF:
            begin
                if (pos_reg == 32'd3 && word_next != wrp_pkg::TAG_RIFF)
                begin
                    fail = 1'b1; fail_code = wrp_pkg::ST_NO_RIFF;
                end
                else if (pos_reg == 32'd7)
                    riff_size_next = word_next;
                else if (pos_reg == 32'd11)
                begin
                    if (word_next != wrp_pkg::TAG_WAVE)
                    begin
                        fail = 1'b1; fail_code = wrp_pkg::ST_NO_WAVE;
                    end
                    else
                    begin
                        phase_next = PH_CHDR; off_next = '0;
                    end
                end
            end
            PH_CHDR:
            begin
                if (off_reg == 32'd3)
                begin
                    tag_next = word_next; off_next = 32'd4;
                end
                else if (off_reg == 32'd7)
                begin
                    off_next = '0;
                    left_next = word_next;
                    phase_next = (word_next == '0) ? PH_CHDR : PH_BODY;
                    if (tag_reg == wrp_pkg::TAG_FMT)
                    begin
                        fmt_seen_next = 1'b1;
                        if (word_next != wrp_pkg::FMT_BODY_SIZE)
                        begin
                            fail = 1'b1; fail_code = wrp_pkg::ST_FMT_SIZE;
                        end
                    end
                    else if (tag_reg == wrp_pkg::TAG_DATA)
                    begin
                        if (!fmt_seen_reg)
                        begin
                            fail = 1'b1; fail_code = wrp_pkg::ST_DATA_EARLY;
                        end
                        else
                        begin
                            data_seen_next = 1'b1; dlen_next = word_next;
                        end
                    end
                    else if (tag_reg == wrp_pkg::TAG_SMPL)
                    begin
                        if (!fmt_seen_reg)
                        begin
                            fail = 1'b1; fail_code = wrp_pkg::ST_SMPL_EARLY;
                        end
                        else if (word_next < wrp_pkg::SMPL_MIN_BODY)
                        begin
                            fail = 1'b1; fail_code = wrp_pkg::ST_TRUNC;
                        end
                    end
                end
                else
                    off_next = off_reg + 32'd1;
            end
            PH_BODY:
            begin
                if (tag_reg == wrp_pkg::TAG_FMT)
                begin
                    case (off_reg[3:0])
                        4'd1:
                            if (off_reg[31:4] == '0 && word_next[31:16] != 16'd1)
                            begin
                                fail = 1'b1; fail_code = wrp_pkg::ST_NOT_PCM;
                            end
                        4'd3:
                            if (off_reg[31:4] == '0 && word_next[31:16] != 16'd1)
                            begin
                                fail = 1'b1; fail_code = wrp_pkg::ST_NOT_MONO;
                            end
                        4'd7:  if (off_reg[31:4] == '0) rate_next = word_next;
                        4'd11: if (off_reg[31:4] == '0) brate_next = word_next;
                        4'd15:
                            if (off_reg[31:4] == '0)
                            begin
                                if ({3'd0, prod[31:3]} != brate_reg)
                                begin
                                    fail = 1'b1; fail_code = wrp_pkg::ST_BYTE_RATE;
                                end
                                else if ({3'd0, word_next[31:19]} != word_next[15:0])
                                begin
                                    fail = 1'b1; fail_code = wrp_pkg::ST_ALIGN;
                                end
                                else
                                    depth_next = word_next[31:16];
                            end
                        default: ;
                    endcase
                end
                else if (tag_reg == wrp_pkg::TAG_SMPL)
                begin
                    if (off_reg == 32'd31 && word_next != 32'd1)
                    begin
                        fail = 1'b1; fail_code = wrp_pkg::ST_LOOP_CNT;
                    end
                    else if (off_reg == 32'd43 && word_next != 32'd0)
                    begin
                        fail = 1'b1; fail_code = wrp_pkg::ST_LOOP_TYPE;
                    end
                    else if (off_reg == 32'd47)
                        lstart_next = word_next;
                    else if (off_reg == 32'd51)
                        lend_next = word_next;
                    else if (off_reg == 32'd59)
                    begin
                        if (word_next != 32'd0)
                        begin
                            fail = 1'b1; fail_code = wrp_pkg::ST_PLAY_CNT;
                        end
                        else if (lstart_reg <= lend_clamp)
                        begin
                            lbeg_next = lstart_reg;
                            lspan_next = lend_clamp - lstart_reg;
                        end
                    end
                end
                else if (tag_reg == wrp_pkg::TAG_DATA)
                begin
                    if (depth_reg == 16'd8)
                    begin
                        smp_valid = 1'b1;
                        smp_res.sample = data_byte - wrp_pkg::SAMPLE_BIAS;
                    end
                    else if (depth_reg == 16'd16 && off_reg[0])
                    begin
                        smp_valid = 1'b1;
                        smp_res.sample = data_byte;
                    end
                end
                if (!fail)
                begin
                    off_next = off_reg + 32'd1;
                    left_next = left_reg - 32'd1;
                    if (left_reg == 32'd1)
                    begin
                        phase_next = PH_CHDR; off_next = '0;
                    end
                end
            end
            default: ;
        endcase

        if (fail)
            phase_next = PH_HALT;
        err_next = (fail && err_reg == wrp_pkg::ST_OK) ? fail_code : err_reg;

        // final report from the updated state
        if (pos_next < 32'd12)
            st = wrp_pkg::ST_SMALL;
        else if (err_next == wrp_pkg::ST_NO_RIFF)
            st = wrp_pkg::ST_NO_RIFF;
        else if ({1'b0, riff_size_next} + 33'd8 != {1'b0, pos_next})
            st = wrp_pkg::ST_SIZE;
        else if (err_next != wrp_pkg::ST_OK)
            st = err_next;
        else if (phase_next == PH_BODY || (phase_next == PH_CHDR && off_next != '0))
            st = wrp_pkg::ST_TRUNC;
        else if (!data_seen_next)
            st = wrp_pkg::ST_NO_DATA;
        else if (depth_next != 16'd8 && depth_next != 16'd16)
            st = wrp_pkg::ST_DEPTH;
        else
            st = wrp_pkg::ST_OK;
        rep_valid = last_byte;
        rep_res.kind = 1'b1;
        rep_res.sample = '0;
        rep_res.status = st;
        rep_res.rate = rate_next;
        rep_res.depth = depth_next;
        rep_res.loop_start = lbeg_next;
        rep_res.loop_length = lspan_next;
        rep_res.sample_count = (depth_next == 16'd16) ? {1'b0, dlen_next[31:1]} : dlen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n || 1'b0)
        begin
            phase_reg <= PH_RIFF;
            pos_reg <= '0; riff_size_reg <= '0; word_reg <= '0; tag_reg <= '0;
            left_reg <= '0; off_reg <= '0; fmt_seen_reg <= 1'b0; data_seen_reg <= 1'b0;
            rate_reg <= '0; depth_reg <= '0; brate_reg <= '0; dlen_reg <= '0;
            lbeg_reg <= '0; lspan_reg <= '0; lend_reg <= '0; lstart_reg <= '0;
            err_reg <= '0;
        end
        else if (step && last_byte)
        begin
            phase_reg <= PH_RIFF;
            pos_reg <= '0; riff_size_reg <= '0; word_reg <= '0; tag_reg <= '0;
            left_reg <= '0; off_reg <= '0; fmt_seen_reg <= 1'b0; data_seen_reg <= 1'b0;
            rate_reg <= '0; depth_reg <= '0; brate_reg <= '0; dlen_reg <= '0;
            lbeg_reg <= '0; lspan_reg <= '0; lend_reg <= '0; lstart_reg <= '0;
            err_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next; riff_size_reg <= riff_size_next; word_reg <= word_next;
            tag_reg <= tag_next; left_reg <= left_next; off_reg <= off_next;
            fmt_seen_reg <= fmt_seen_next; data_seen_reg <= data_seen_next;
            rate_reg <= rate_next; depth_reg <= depth_next; brate_reg <= brate_next;
            dlen_reg <= dlen_next; lbeg_reg <= lbeg_next; lspan_reg <= lspan_next;
            lend_reg <= lend_next; lstart_reg <= lstart_next; err_reg <= err_next;
        end
    end
endmodule
`default_nettype wire

### sv/wrp_out_fifo.sv
// Small result queue: takes up to two results a cycle, hands out one.
`timescale 1ns / 1ps
`default_nettype none
module wrp_out_fifo
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             a_valid,
    input  wire wrp_pkg::result_t a_res,
    input  wire logic             b_valid,
    input  wire wrp_pkg::result_t b_res,
    output      logic             room,      // space for two more results
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      wrp_pkg::result_t out_res
);
    wrp_pkg::result_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       pop;
    logic [1:0] nin;
    logic [1:0] wp_b;

    assign pop = out_valid && out_ready;
    assign nin = {1'b0, a_valid} + {1'b0, b_valid};
    assign room = (cnt_reg <= 3'd2);
    assign out_valid = (cnt_reg != '0);
    assign out_res = mem_reg[rp_reg];
    assign wp_b = a_valid ? wp_reg + 2'd1 : wp_reg;

    always_ff @(posedge clk)
    begin
        if (a_valid)
            mem_reg[wp_reg] <= a_res;
        if (b_valid)
            mem_reg[wp_b] <= b_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_reg + nin;
            if (pop)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {1'b0, nin} - {2'b0, pop};
        end
    end
endmodule
`default_nettype wire

### sv/wrp_checker.sv
// Port-level checker for the RIFF/WAVE stream parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "wav_riff_stream_parser_assert.svh"
module wrp_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         s_axis_tlast,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [159:0] m_axis_tdata,
    input wire logic         m_axis_tuser
);
    `WRP_ASSERT_NXT(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `WRP_ASSERT_IMP(a_sample_clean, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[159:8] == '0)
    `WRP_ASSERT_IMP(a_status_range, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[12:8] <= 5'd17)
    `WRP_ASSERT_NXT(a_last_gives_out, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, m_axis_tvalid)
endmodule
bind wav_riff_stream_parser wrp_checker u_wrp_checker
(
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

### tb/wav_riff_stream_parser_checker.sv
// Stream checker for the RIFF/WAVE parser: predicts results per byte and compares them.
`timescale 1ns / 1ps
module wav_riff_stream_parser_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [159:0] m_axis_tdata,
    input  logic         m_axis_tuser,
    output int           errors,
    output int           pending
);
    typedef enum logic [1:0] {P_HEADER, P_CHUNK_HDR, P_BODY, P_HALTED} phase_t;

    phase_t      phase;
    logic [31:0] byte_pos, riff_size, shift_word, chunk_tag, bytes_left, body_off;
    logic        have_fmt, have_data;
    logic [31:0] rate, bytes_per_sec, data_len, loop_begin, loop_span, loop_end, loop_start;
    logic [15:0] depth;
    logic [4:0]  first_err;

    wrp_pkg::result_t expected_results[$];

    assign pending = expected_results.size();

    task automatic clear_parser();
        phase = P_HEADER;
        byte_pos = '0; riff_size = '0; shift_word = '0; chunk_tag = '0;
        bytes_left = '0; body_off = '0; have_fmt = 1'b0; have_data = 1'b0;
        rate = '0; bytes_per_sec = '0; data_len = '0; depth = '0;
        loop_begin = '0; loop_span = '0; loop_end = '0; loop_start = '0;
        first_err = wrp_pkg::ST_OK;
    endtask

    task automatic halt(input logic [4:0] code);
        if (first_err == wrp_pkg::ST_OK)
            first_err = code;
        phase = P_HALTED;
    endtask

    task automatic fmt_field(input logic [31:0] off, input logic [31:0] w);
        logic [15:0] bits, align;
        logic [31:0] prod;
        bits = w[31:16];
        align = w[15:0];
        case (off)
            1:  if (w[31:16] != 16'd1) halt(wrp_pkg::ST_NOT_PCM);
            3:  if (w[31:16] != 16'd1) halt(wrp_pkg::ST_NOT_MONO);
            7:  rate = w;
            11: bytes_per_sec = w;
            15:
            begin
                prod = rate * {16'd0, bits};
                if ((prod >> 3) != bytes_per_sec) halt(wrp_pkg::ST_BYTE_RATE);
                else if ((bits >> 3) != align) halt(wrp_pkg::ST_ALIGN);
                else depth = bits;
            end
            default: ;
        endcase
    endtask

    task automatic smpl_field(input logic [31:0] off, input logic [31:0] w);
        logic [31:0] clamp;
        case (off)
            31: if (w != 32'd1) halt(wrp_pkg::ST_LOOP_CNT);
            43: if (w != 32'd0) halt(wrp_pkg::ST_LOOP_TYPE);
            47: loop_start = w;
            51: loop_end = w;
            59:
            begin
                if (w != 32'd0)
                    halt(wrp_pkg::ST_PLAY_CNT);
                else
                begin
                    clamp = (loop_end > data_len) ? data_len : loop_end;
                    // a loop starting past its end leaves any earlier loop alone
                    if (loop_start <= clamp)
                    begin
                        loop_begin = loop_start;
                        loop_span = clamp - loop_start;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic end_chunk_header();
        logic [31:0] size;
        size = shift_word;
        body_off = '0;
        bytes_left = size;
        if (chunk_tag == wrp_pkg::TAG_FMT)
        begin
            have_fmt = 1'b1;
            if (size != wrp_pkg::FMT_BODY_SIZE)
            begin
                halt(wrp_pkg::ST_FMT_SIZE);
                return;
            end
        end
        else if (chunk_tag == wrp_pkg::TAG_DATA)
        begin
            if (!have_fmt)
            begin
                halt(wrp_pkg::ST_DATA_EARLY);
                return;
            end
            have_data = 1'b1;
            data_len = size;
        end
        else if (chunk_tag == wrp_pkg::TAG_SMPL)
        begin
            if (!have_fmt)
            begin
                halt(wrp_pkg::ST_SMPL_EARLY);
                return;
            end
            if (size < wrp_pkg::SMPL_MIN_BODY)
            begin
                halt(wrp_pkg::ST_TRUNC);
                return;
            end
        end
        phase = (size == 0) ? P_CHUNK_HDR : P_BODY;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [31:0]      pos;
        wrp_pkg::result_t r;
        pos = byte_pos;
        if (byte_pos != 32'hFFFF_FFFF)
            byte_pos = byte_pos + 1;
        shift_word = {b, shift_word[31:8]};
        case (phase)
            P_HEADER:
            begin
                if (pos == 3 && shift_word != wrp_pkg::TAG_RIFF) halt(wrp_pkg::ST_NO_RIFF);
                else if (pos == 7) riff_size = shift_word;
                else if (pos == 11)
                begin
                    if (shift_word != wrp_pkg::TAG_WAVE) halt(wrp_pkg::ST_NO_WAVE);
                    else
                    begin
                        phase = P_CHUNK_HDR;
                        body_off = '0;
                    end
                end
            end
            P_CHUNK_HDR:
            begin
                if (body_off == 3)
                begin
                    chunk_tag = shift_word;
                    body_off = 4;
                end
                else if (body_off == 7)
                    end_chunk_header();
                else
                    body_off = body_off + 1;
            end
            P_BODY:
            begin
                if (chunk_tag == wrp_pkg::TAG_FMT)
                    fmt_field(body_off, shift_word);
                else if (chunk_tag == wrp_pkg::TAG_SMPL)
                    smpl_field(body_off, shift_word);
                else if (chunk_tag == wrp_pkg::TAG_DATA)
                begin
                    r = '0;
                    if (depth == 16'd8)
                    begin
                        r.sample = b - wrp_pkg::SAMPLE_BIAS;
                        expected_results.push_back(r);
                    end
                    else if (depth == 16'd16 && body_off[0])
                    begin
                        r.sample = b;
                        expected_results.push_back(r);
                    end
                end
                if (phase == P_BODY)
                begin
                    body_off = body_off + 1;
                    bytes_left = bytes_left - 1;
                    if (bytes_left == 0)
                    begin
                        phase = P_CHUNK_HDR;
                        body_off = '0;
                    end
                end
            end
            default: ;
        endcase

        if (last)
        begin
            r = '0;
            r.kind = 1'b1;
            if (byte_pos < 12) r.status = wrp_pkg::ST_SMALL;
            else if (first_err == wrp_pkg::ST_NO_RIFF) r.status = wrp_pkg::ST_NO_RIFF;
            else if ({1'b0, riff_size} + 33'd8 != {1'b0, byte_pos})
                r.status = wrp_pkg::ST_SIZE;
            else if (first_err != wrp_pkg::ST_OK) r.status = first_err;
            else if (phase == P_BODY || (phase == P_CHUNK_HDR && body_off != 0))
                r.status = wrp_pkg::ST_TRUNC;
            else if (!have_data) r.status = wrp_pkg::ST_NO_DATA;
            else if (depth != 16'd8 && depth != 16'd16) r.status = wrp_pkg::ST_DEPTH;
            else r.status = wrp_pkg::ST_OK;
            r.rate = rate;
            r.depth = depth;
            r.loop_start = loop_begin;
            r.loop_length = loop_span;
            r.sample_count = (depth == 16'd16) ? (data_len >> 1) : data_len;
            expected_results.push_back(r);
            clear_parser();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    initial
    begin
        errors = 0;
        clear_parser();
    end

    always @(posedge clk)
    begin
        wrp_pkg::result_t e;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual kind %0d data %0h",
                             $time, m_axis_tuser, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("kind", e.kind, m_axis_tuser);
                    check_field("sample", e.sample, m_axis_tdata[7:0]);
                    check_field("status", e.status, m_axis_tdata[12:8]);
                    check_field("rate", e.rate, m_axis_tdata[44:13]);
                    check_field("depth", e.depth, m_axis_tdata[60:45]);
                    check_field("loop_start", e.loop_start, m_axis_tdata[92:61]);
                    check_field("loop_length", e.loop_length, m_axis_tdata[124:93]);
                    check_field("sample_count", e.sample_count, m_axis_tdata[156:125]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata, s_axis_tlast);
        end
    end
endmodule

### tb/wav_riff_stream_parser_tb.sv
// Top of the RIFF/WAVE parser testbench: builds WAV files and streams them in.
`timescale 1ns / 1ps
module wav_riff_stream_parser_tb;
    localparam int F_NONE       = 0;
    localparam int F_SMALL      = 1;
    localparam int F_RIFF       = 2;
    localparam int F_SIZE       = 3;
    localparam int F_WAVE       = 4;
    localparam int F_FMT_SIZE   = 5;
    localparam int F_PCM        = 6;
    localparam int F_MONO       = 7;
    localparam int F_RATE       = 8;
    localparam int F_ALIGN      = 9;
    localparam int F_DATA_EARLY = 10;
    localparam int F_SMPL_EARLY = 11;
    localparam int F_LOOP_CNT   = 12;
    localparam int F_LOOP_TYPE  = 13;
    localparam int F_PLAY_CNT   = 14;
    localparam int F_NO_DATA    = 15;
    localparam int F_DEPTH      = 16;
    localparam int F_TRUNC      = 17;
    localparam int F_SHORT_SMPL = 18;
    localparam int F_NOISE      = 19;
    localparam int F_LAST       = 19;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic         m_axis_tuser;
    int           errors;
    int           pending;
    logic         idle_on;
    int           bytes_sent;
    logic [7:0]   file_bytes[$];

    wav_riff_stream_parser dut (.*);

    wav_riff_stream_parser_checker chk (.*);

    always
    begin
        clk = 1'b1; #2;
        clk = 1'b0; #2;
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            m_axis_tready <= idle_on ? ($urandom_range(99) >= 9) : 1'b1;
        end
    end

    task automatic put32(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(w[8*i +: 8]);
    endtask

    task automatic put_random(input int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(8'($urandom));
    endtask

    task automatic put_data(input int n);
        put32(wrp_pkg::TAG_DATA);
        put32(n);
        put_random(n);
    endtask

    task automatic put_smpl(input int flaw);
        logic [31:0] w;
        int          words;
        words = (flaw == F_SHORT_SMPL) ? 10 : 15;
        put32(wrp_pkg::TAG_SMPL);
        put32(words * 4);
        for (int i = 0; i < words; i++)
        begin
            w = $urandom;
            case (i)
                7:  w = (flaw == F_LOOP_CNT) ? $urandom_range(5, 2) : 1;
                10: w = (flaw == F_LOOP_TYPE) ? $urandom_range(3, 1) : 0;
                11: w = $urandom_range(40);
                12: w = $urandom_range(3) == 0 ? $urandom : $urandom_range(50);
                14: w = (flaw == F_PLAY_CNT) ? $urandom_range(9, 1) : 0;
                default: ;
            endcase
            put32(w);
        end
    endtask

    task automatic put_unknown();
        int n;
        n = $urandom_range(5);
        put32($urandom);
        put32(n);
        put_random(n);
    endtask

    task automatic make_file(input int flaw);
        logic [31:0] rate, bytes_per_sec;
        logic [15:0] bits;
        int          n, with_smpl;
        file_bytes.delete();
        if (flaw == F_SMALL)
        begin
            put32(wrp_pkg::TAG_RIFF);
            put32(32'd3);
            put_random(4);
            n = $urandom_range(11, 1);
            while (file_bytes.size() > n)
                void'(file_bytes.pop_back());
            return;
        end
        if (flaw == F_NOISE)
        begin
            put_random($urandom_range(40, 1));
            return;
        end
        put32(wrp_pkg::TAG_RIFF);
        put32(0);
        put32(wrp_pkg::TAG_WAVE);
        if ($urandom_range(3) == 0) put_unknown();
        if (flaw == F_DATA_EARLY) put_data($urandom_range(6));
        if (flaw == F_SMPL_EARLY) put_smpl(F_NONE);
        case ($urandom_range(9))
            0: rate = 32'd0;
            1: rate = 32'hFFFF_FFFF;
            2: rate = $urandom;
            default: rate = $urandom_range(48000, 8000);
        endcase
        bits = (flaw == F_DEPTH) ? 16'd24 : ($urandom_range(1) ? 16'd8 : 16'd16);
        bytes_per_sec = (rate * {16'd0, bits}) >> 3;
        put32(wrp_pkg::TAG_FMT);
        put32(flaw == F_FMT_SIZE ? 18 : 16);
        put32({(flaw == F_MONO) ? 16'd2 : 16'd1, (flaw == F_PCM) ? 16'd3 : 16'd1});
        put32(rate);
        put32(flaw == F_RATE ? bytes_per_sec + 1 : bytes_per_sec);
        put32({bits, 16'(bits >> 3) + ((flaw == F_ALIGN) ? 16'd1 : 16'd0)});
        if (flaw == F_FMT_SIZE) put_random(2);
        with_smpl = (flaw >= F_LOOP_CNT && flaw <= F_PLAY_CNT) || flaw == F_SHORT_SMPL
                    || $urandom_range(3) == 0;
        if (with_smpl && $urandom_range(1)) put_smpl(flaw);
        if (flaw != F_NO_DATA)
        begin
            put_data($urandom_range(16));
            if ($urandom_range(3) == 0) put_data($urandom_range(9));
        end
        if (with_smpl && file_bytes.size() > 0 && $urandom_range(1)) put_smpl(flaw);
        if ($urandom_range(4) == 0) put_unknown();
        if (flaw == F_TRUNC)
            for (int i = $urandom_range(6, 1); i > 0; i--)
                void'(file_bytes.pop_back());
        n = file_bytes.size() - 8;
        if (flaw == F_SIZE) n = n + $urandom_range(9, 1) * ($urandom_range(1) ? 1 : -1);
        for (int i = 0; i < 4; i++)
            file_bytes[4 + i] = 8'(n >> (8 * i));
        if (flaw == F_RIFF) file_bytes[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
        if (flaw == F_WAVE) file_bytes[8 + $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
    endtask

    // Drive one item; ready is read at the falling edge, where it is settled.
    task automatic send_item(input logic [7:0] b, input logic last);
        logic rdy;
        // a stretch in the middle of the run goes without any idling
        idle_on = !(bytes_sent > 400 && bytes_sent < 700);
        while (idle_on && $urandom_range(99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        do
        begin
            @(negedge clk);
            rdy = s_axis_tready;
            @(posedge clk);
        end while (!rdy);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_item(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        idle_on = 1'b1;
        bytes_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int f = 0; f <= F_LAST; f++)
        begin
            make_file(f);
            send_file();
        end
        s_axis_tvalid <= 1'b0;
        // hold off until the block has drained everything
        while (pending != 0)
            @(posedge clk);

        while (bytes_sent < 1300)
        begin
            make_file($urandom_range(2) != 0 ? F_NONE : $urandom_range(F_LAST, 1));
            send_file();
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("wav_riff_stream_parser regression: pass");
        else
            $display("wav_riff_stream_parser regression: fail");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("wav_riff_stream_parser regression: fail");
        $finish;
    end
endmodule
